[hw/rtl/bitmap_block_allocator_unit_macros.svh]
// assertion helpers for the bitmap allocator
// both sample on the rising edge of clk and stay quiet while rst_n is low
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bba_pkg.sv]
`default_nettype none

package bba_pkg;

  localparam int NUM_BLOCKS  = 256;
  localparam int TABLE_BYTES = 32;

  localparam int IDX_W      = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
  localparam int SCAN_BYTES = (TABLE_BYTES < (NUM_BLOCKS + 7) / 8) ?
                              TABLE_BYTES : (NUM_BLOCKS + 7) / 8;
  localparam int BLK_W      = 14;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(SCAN_BYTES - 1);
  localparam logic [BLK_W-1:0] BLK_LIMIT  = BLK_W'(NUM_BLOCKS);
  localparam logic [BLK_W-1:0] BYTE_LIMIT = BLK_W'(TABLE_BYTES);
  localparam logic [8:0]       FULL_ID    = 9'(NUM_BLOCKS);

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_LOAD  = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  block_id;
    logic [7:0]  load_byte;
    logic        batch_end;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  result_id;
    logic        is_used;
    logic        write_valid;
    logic [11:0] write_addr;
    logic [7:0]  write_byte;
    logic        batch_done;
  } out_item_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  pos;
    logic [7:0]  set_byte;
    logic [7:0]  clr_byte;
    logic        bit_val;
  } bit_res_t;

endpackage

`default_nettype wire

[hw/rtl/bitmap_block_allocator_unit.sv]
// Bitmap first-fit block allocator, one bit per storage block (1 = used).
// Input channel in_valid/in_ready/in_data carries one request beat: allocate,
// free, query or load of one bitmap byte. Output channel out_valid/out_ready/
// out_data returns exactly one result beat per request, in order; allocate and
// free also carry the external write (address and updated bitmap byte) when the
// block is in range or one is found. cfg_wr_en/cfg_wr_data set table_base, the external address of bitmap byte 0.
// One request is in flight at a time. A load goes from accept straight to the
// result state; free and query pass through the evaluate state first. The
// allocate scan stays in evaluate and reads one bitmap byte per cycle from the
// bitmap RAM until it finds a free block or has checked the last byte, which
// reports the bitmap full. The next request is taken once the result has left
// the result state. in_ready is high whenever the sequencer is idle,
// also while a finished result waits in the output register.
// Reset clears table_base and marks every block free at once; no sweep.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits with the next result until the register frees up.
`default_nettype none

module bitmap_block_allocator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bba_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bba_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic        [11:0] cfg_wr_data
);
  import bba_pkg::*;

  logic [11:0] table_base_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        res_valid;
  out_item_t   res_data;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .table_base (table_base_r),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .slot_free  (slot_free)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_base_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        table_base_r <= cfg_wr_data;
      end
      if (res_valid && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_valid && slot_free) begin
      out_data_r <= res_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bba_ram.sv]
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hw/rtl/bba_bitop.sv]
`default_nettype none

module bba_bitop (
  input  logic              [7:0] data_in,
  input  logic              [2:0] bit_sel,
  input  logic              [7:0] lane_mask,
  output bba_pkg::bit_res_t       res
);
  import bba_pkg::*;

  logic [7:0] free_bits;

  // lowest clear bit among the lanes that map to real blocks
  always_comb begin
    free_bits    = ~data_in & lane_mask;
    res.found    = |free_bits;
    res.pos      = 3'd0;
    for (int n = 7; n >= 0; n--) begin
      if (free_bits[n]) begin
        res.pos = 3'(n);
      end
    end
    res.set_byte = data_in | (8'h01 << res.pos);
    res.clr_byte = data_in & ~(8'h01 << bit_sel);
    res.bit_val  = data_in[bit_sel];
  end

endmodule

`default_nettype wire

[hw/rtl/bba_ctrl.sv]
`default_nettype none

`include "bitmap_block_allocator_unit_macros.svh"

module bba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bba_pkg::in_item_t   in_data,
  input  logic         [11:0] table_base,
  output logic                res_valid,
  output bba_pkg::out_item_t  res_data,
  input  logic                slot_free
);
  import bba_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  in_item_t               req_r, req_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  out_item_t              res_r, res_nxt;
  logic [TABLE_BYTES-1:0] vld_r, vld_nxt;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [IDX_W-1:0]       ram_raddr;
  logic [7:0]             ram_wdata;
  logic [7:0]             ram_rdata;
  logic [7:0]             cur_byte;
  logic [7:0]             lane_mask;
  bit_res_t               bop;
  logic                   accept;
  logic                   id_ok;
  logic                   load_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == S_FIN);
  assign res_data  = res_r;

  assign id_ok   = (BLK_W'(req_r.block_id) < BLK_LIMIT) &&
                   (BLK_W'(req_r.block_id >> 3) < BYTE_LIMIT);
  assign load_ok = (BLK_W'(in_data.block_id) < BYTE_LIMIT);

  // never-written bytes read as all free
  assign cur_byte = vld_r[idx_r] ? ram_rdata : 8'h00;

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      lane_mask[n] = (BLK_W'({idx_r, 3'(n)}) < BLK_LIMIT);
    end
  end

  bba_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  bba_bitop u_bitop (
    .data_in   (cur_byte),
    .bit_sel   (req_r.block_id[2:0]),
    .lane_mask (lane_mask),
    .res       (bop)
  );

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    res_nxt   = res_r;
    vld_nxt   = vld_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = bop.set_byte;
    ram_raddr = idx_r + 1'b1;

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = (in_data.req_type == REQ_ALLOC) ? '0 : IDX_W'(in_data.block_id >> 3);
        if (accept) begin
          req_nxt = in_data;
          idx_nxt = ram_raddr;
          if (in_data.req_type == REQ_LOAD) begin
            res_nxt            = '0;
            res_nxt.result_id  = {1'b0, in_data.block_id};
            res_nxt.batch_done = in_data.batch_end;
            if (load_ok) begin
              ram_we             = 1'b1;
              ram_waddr          = IDX_W'(in_data.block_id);
              ram_wdata          = in_data.load_byte;
              vld_nxt[ram_waddr] = 1'b1;
            end
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        res_nxt            = '0;
        res_nxt.result_id  = {1'b0, req_r.block_id};
        res_nxt.batch_done = req_r.batch_end;
        state_nxt          = S_FIN;
        case (req_r.req_type)
          REQ_ALLOC: begin
            if (bop.found) begin
              ram_we              = 1'b1;
              ram_wdata           = bop.set_byte;
              vld_nxt[idx_r]      = 1'b1;
              res_nxt.result_id   = 9'({idx_r, bop.pos});
              res_nxt.write_valid = 1'b1;
              res_nxt.write_addr  = table_base + 12'(idx_r);
              res_nxt.write_byte  = bop.set_byte;
            end else if (idx_r != LAST_IDX) begin
              // next byte was read this cycle, keep scanning
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_EVAL;
            end else begin
              res_nxt.result_id = FULL_ID;
            end
          end
          REQ_FREE: begin
            if (id_ok) begin
              ram_we              = 1'b1;
              ram_wdata           = bop.clr_byte;
              vld_nxt[idx_r]      = 1'b1;
              res_nxt.write_valid = 1'b1;
              res_nxt.write_addr  = table_base + 12'(idx_r);
              res_nxt.write_byte  = bop.clr_byte;
            end
          end
          REQ_QUERY: begin
            res_nxt.is_used = id_ok && bop.bit_val;
          end
          default: begin
          end
        endcase
      end

      S_FIN: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    req_r <= req_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  `BBA_ASSERT_NXT(a_accept_leaves_idle, accept, state_r != S_IDLE, "accepted beat left idle")
  `BBA_ASSERT_IMP(a_no_write_in_fin, state_r == S_FIN, !ram_we, "bitmap write while holding result")
  `BBA_ASSERT_NXT(a_single_eval,
                  state_r == S_EVAL && req_r.req_type != REQ_ALLOC,
                  state_r == S_FIN, "free or query stayed in evaluate")
  `BBA_ASSERT_IMP(a_alloc_byte_used,
                  res_valid && res_r.write_valid && req_r.req_type == REQ_ALLOC,
                  res_r.write_byte != 8'h00, "allocate persisted an empty byte")

endmodule

`default_nettype wire

[tb/sv/bba_result_checker.sv]
`default_nettype none

module bba_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bba_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  bba_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic        [11:0] cfg_wr_data,
  output int unsigned        fail_count,
  output int unsigned        awaited_count,
  output int unsigned        checked_count,
  output int unsigned        full_count
);
  import bba_pkg::*;

  logic [7:0]  shadow_map [TABLE_BYTES];
  logic [11:0] shadow_base;
  out_item_t   awaited_replies [$];

  function automatic bit block_in_table(int unsigned blk);
    return blk < NUM_BLOCKS && (blk >> 3) < TABLE_BYTES;
  endfunction

  // applies one request to the shadow bitmap and returns the reply it owes
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t   reply;
    int unsigned blk;
    int unsigned byte_idx;
    bit          placed;
    reply            = '0;
    reply.result_id  = {1'b0, req.block_id};
    reply.batch_done = req.batch_end;
    blk              = req.block_id;
    byte_idx         = blk >> 3;
    placed           = 1'b0;
    case (req.req_type)
      REQ_ALLOC: begin
        reply.result_id = FULL_ID;
        // first fit: lowest clear bit over the valid blocks only
        for (blk = 0; block_in_table(blk) && !placed; blk++) begin
          byte_idx = blk >> 3;
          if (!shadow_map[byte_idx][blk % 8]) begin
            shadow_map[byte_idx][blk % 8] = 1'b1;
            reply.result_id   = 9'(blk);
            reply.write_valid = 1'b1;
            reply.write_addr  = shadow_base + 12'(byte_idx);
            reply.write_byte  = shadow_map[byte_idx];
            placed            = 1'b1;
          end
        end
      end
      REQ_FREE: begin
        // freeing a free block still persists the byte
        if (block_in_table(blk)) begin
          shadow_map[byte_idx][blk % 8] = 1'b0;
          reply.write_valid = 1'b1;
          reply.write_addr  = shadow_base + 12'(byte_idx);
          reply.write_byte  = shadow_map[byte_idx];
        end
      end
      REQ_QUERY: begin
        if (block_in_table(blk)) begin
          reply.is_used = shadow_map[byte_idx][blk % 8];
        end
      end
      REQ_LOAD: begin
        if (req.block_id < TABLE_BYTES) begin
          shadow_map[req.block_id] = req.load_byte;
        end
      end
    endcase
    return reply;
  endfunction

  function automatic bit field_differs(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v === got_v) begin
      return 1'b0;
    end
    $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    bit        bad;
    if (!rst_n) begin
      foreach (shadow_map[i]) begin
        shadow_map[i] = '0;
      end
      shadow_base = '0;
      awaited_replies.delete();
      fail_count    = 0;
      awaited_count = 0;
      checked_count = 0;
      full_count    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: reply beat %h arrived with nothing awaited", $time, out_data);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          bad  = field_differs("result_id", 32'(want.result_id), 32'(out_data.result_id))
               | field_differs("is_used", 32'(want.is_used), 32'(out_data.is_used))
               | field_differs("write_valid", 32'(want.write_valid), 32'(out_data.write_valid))
               | field_differs("write_addr", 32'(want.write_addr), 32'(out_data.write_addr))
               | field_differs("write_byte", 32'(want.write_byte), 32'(out_data.write_byte))
               | field_differs("batch_done", 32'(want.batch_done), 32'(out_data.batch_done));
          if (bad) begin
            fail_count++;
          end
          if (want.result_id == FULL_ID) begin
            full_count++;
          end
          checked_count++;
        end
      end
      if (in_valid && in_ready) begin
        awaited_replies.push_back(serve_request(in_data));
      end
      if (cfg_wr_en) begin
        shadow_base = cfg_wr_data;
      end
      awaited_count = awaited_replies.size();
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none

module tb_top;
  import bba_pkg::*;

  localparam int unsigned ITEM_TARGET = 1400;
  localparam int unsigned CALM_TAIL   = 150;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned LONG_HOLD   = 80;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  in_item_t    in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [11:0] cfg_wr_data = '0;

  int unsigned fail_count;
  int unsigned awaited_count;
  int unsigned checked_count;
  int unsigned full_count;
  int unsigned sent_count  = 0;
  int unsigned base_writes = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;
  bit          long_hold   = 1'b0;

  bitmap_block_allocator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bba_result_checker replies (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .awaited_count (awaited_count),
    .checked_count (checked_count),
    .full_count    (full_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bitmap_block_allocator_unit verification failed");
      $finish;
    end
  end

  function automatic in_item_t make_req(req_type_t kind, logic [7:0] id, logic [7:0] lb,
                                        logic last);
    in_item_t req;
    req.req_type  = kind;
    req.block_id  = id;
    req.load_byte = lb;
    req.batch_end = last;
    return req;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic push_request(input in_item_t req);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
    if (sent_count >= ITEM_TARGET - CALM_TAIL) begin
      calm = 1'b1;
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
  endtask

  task automatic set_table_base(input logic [11:0] base);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    base_writes++;
  endtask

  // result side: short random stalls, plus a long hold-off each time one is requested
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (long_hold) begin
        long_hold  = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    in_item_t    req;
    logic [18:0] raw;
    logic [7:0]  fill;
    logic [11:0] base_plan [4];
    int unsigned free_bits;
    int unsigned n;
    int unsigned k;
    int unsigned mode;
    int unsigned scen;
    int unsigned i;

    base_plan[0] = 12'hFFF;
    base_plan[1] = 12'h000;
    base_plan[2] = 12'hFE0;
    base_plan[3] = 12'h001;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // top of the address space first, so persistence addresses wrap
    set_table_base(base_plan[0]);
    push_request(make_req(REQ_QUERY, 8'd0, 8'h00, 1'b0));
    push_request(make_req(REQ_ALLOC, 8'd0, 8'h00, 1'b0));
    push_request(make_req(REQ_ALLOC, 8'hFF, 8'hFF, 1'b1));
    push_request(make_req(REQ_QUERY, 8'd1, 8'h00, 1'b0));
    push_request(make_req(REQ_FREE, 8'd1, 8'h00, 1'b1));
    // free of a block that is already free
    push_request(make_req(REQ_FREE, 8'd1, 8'h00, 1'b0));
    push_request(make_req(REQ_ALLOC, 8'd0, 8'h00, 1'b0));
    push_request(make_req(REQ_LOAD, 8'd31, 8'hFF, 1'b0));
    push_request(make_req(REQ_QUERY, 8'd255, 8'h00, 1'b0));
    push_request(make_req(REQ_FREE, 8'd255, 8'h00, 1'b1));
    push_request(make_req(REQ_QUERY, 8'd255, 8'h00, 1'b0));
    // load index beyond the table is ignored
    push_request(make_req(REQ_LOAD, 8'd32, 8'hAA, 1'b0));
    push_request(make_req(REQ_LOAD, 8'd255, 8'h00, 1'b1));
    push_request(make_req(REQ_LOAD, 8'd0, 8'hFF, 1'b0));
    push_request(make_req(REQ_ALLOC, 8'd0, 8'h00, 1'b0));
    push_request(make_req(REQ_QUERY, 8'd8, 8'h00, 1'b0));
    push_request(make_req(REQ_LOAD, 8'd0, 8'h00, 1'b0));
    push_request(make_req(REQ_QUERY, 8'd0, 8'h00, 1'b0));
    push_request(make_req(REQ_FREE, 8'd0, 8'h00, 1'b1));
    push_request(make_req(REQ_LOAD, 8'd31, 8'h00, 1'b0));
    push_request(make_req(REQ_QUERY, 8'd200, 8'hFF, 1'b1));

    scen = 0;
    while (sent_count < ITEM_TARGET) begin
      scen++;
      if (scen % 10 == 0) begin
        set_table_base((scen / 10 < 4) ? base_plan[scen / 10] : 12'($urandom));
      end
      if (scen == 5 || scen == 30) begin
        long_hold = 1'b1;
      end
      if (scen == 9 || scen == 40) begin
        wait_for_drain();
      end
      k = $urandom_range(0, 9);
      if (k < 5) begin
        // allocate a few, look around, then free a batch
        n = $urandom_range(1, 10);
        repeat (n) begin
          push_request(make_req(REQ_ALLOC, 8'($urandom), 8'($urandom), 1'($urandom)));
        end
        repeat ($urandom_range(0, 3)) begin
          push_request(make_req(REQ_QUERY, 8'($urandom_range(0, 63)), 8'($urandom), 1'b0));
        end
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          push_request(make_req(REQ_FREE,
                                8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(0, 63)),
                                8'($urandom), i == n - 1));
        end
      end else if (k < 7) begin
        // reload the whole table, then allocate until it runs out or up to 40 times
        mode      = $urandom_range(0, 2);
        free_bits = 0;
        for (i = 0; i < TABLE_BYTES; i++) begin
          case (mode)
            0:       fill = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'hFF;
            1:       fill = 8'($urandom);
            default: fill = 8'h00;
          endcase
          free_bits += 8 - $countones(fill);
          push_request(make_req(REQ_LOAD, 8'(i), fill, 1'($urandom)));
        end
        n = (free_bits + 2 < 40) ? free_bits + 2 : 40;
        repeat (n) begin
          push_request(make_req(REQ_ALLOC, 8'($urandom), 8'($urandom), 1'b0));
        end
        repeat (4) begin
          push_request(make_req(REQ_QUERY, 8'($urandom), 8'($urandom), 1'($urandom)));
        end
      end else begin
        // unstructured beats over the full field ranges
        repeat ($urandom_range(5, 15)) begin
          raw = 19'($urandom);
          req = raw;
          push_request(req);
        end
      end
    end

    wait_for_drain();
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("sent %0d requests of all four kinds under %0d table base settings",
             sent_count, base_writes);
    $display("compared %0d reply beats, %0d of them on a full table", checked_count,
             full_count);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("bitmap_block_allocator_unit verification clean");
    end else begin
      $display("bitmap_block_allocator_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
